// ----- sv/fat12_packed_table_engine_unit_defines.svh -----
// Assertion macros for the checker file of the FAT12 table engine.
// No dependencies; include by bare file name.
`ifndef FAT12_PACKED_TABLE_ENGINE_UNIT_DEFINES_SVH
`define FAT12_PACKED_TABLE_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FAT12PT_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fat12pt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FAT12PT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fat12pt assertion failed");

`endif

// ----- sv/fat12pt_pkg.sv -----
// Shared constants, types and entry-offset helpers for the FAT12 table engine.
// No dependencies.
package fat12pt_pkg;

	localparam int TABLE_BYTES = 6144;
	localparam int SCAN_END    = 4084;

	localparam int FUNC_W  = 3;
	localparam int CL_W    = 12;
	localparam int EV_W    = 12;
	localparam int BADDR_W = 13;
	localparam int BYTE_W  = 8;

	// Bytes are split over an even bank and an odd bank.
	localparam int BANK_DEPTH = (TABLE_BYTES + 1) / 2;
	localparam int BA_W       = $clog2(BANK_DEPTH);
	localparam int OFF_W      = 14;
	localparam int SCAN_W     = $clog2(SCAN_END + 1);

	localparam logic [CL_W-1:0] FIRST_DATA_CLUSTER = 12'd2;

	typedef enum logic [FUNC_W-1:0] {
		FN_READ_ENTRY  = 3'd0,
		FN_WRITE_ENTRY = 3'd1,
		FN_FIND_FREE   = 3'd2,
		FN_LOAD_BYTE   = 3'd3,
		FN_READ_BYTE   = 3'd4
	} func_t;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_ACCESS = 5'b00100,
		ST_SCAN   = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	typedef struct packed {
		logic              we;
		logic [BA_W-1:0]   waddr;
		logic [BYTE_W-1:0] wdata;
		logic [BA_W-1:0]   raddr;
	} mem_req_t;

	typedef struct packed {
		logic              valid;
		logic [CL_W-1:0]   read_entry;
		logic [BYTE_W-1:0] read_byte;
		logic [CL_W-1:0]   free_cluster;
		logic              found;
	} res_t;

	// Entry n starts at byte n + n/2.
	function automatic logic [OFF_W-1:0] entry_off(input logic [CL_W-1:0] n);
		return OFF_W'(n) + OFF_W'(n[CL_W-1:1]);
	endfunction

	// Both bytes of the entry must lie inside the store.
	function automatic logic entry_inside(input logic [OFF_W-1:0] off);
		return (off + OFF_W'(1)) < OFF_W'(TABLE_BYTES);
	endfunction

endpackage

// ----- sv/fat12pt_req_if.sv -----
// Request channel of the FAT12 table engine: valid/ready plus operation fields.
// Depends on fat12pt_pkg.
interface fat12pt_req_if
	import fat12pt_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [CL_W-1:0]    cluster;
	logic [EV_W-1:0]    entry_value;
	logic [BADDR_W-1:0] byte_addr;
	logic [BYTE_W-1:0]  byte_data;

	modport source (output valid, func, cluster, entry_value, byte_addr, byte_data,
		input ready);
	modport sink (input valid, func, cluster, entry_value, byte_addr, byte_data,
		output ready);
endinterface

// ----- sv/fat12pt_rsp_if.sv -----
// Response channel of the FAT12 table engine: valid/ready plus result fields.
// Depends on fat12pt_pkg.
interface fat12pt_rsp_if
	import fat12pt_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [CL_W-1:0]   read_entry;
	logic [BYTE_W-1:0] read_byte;
	logic [CL_W-1:0]   free_cluster;
	logic              found;

	modport source (output valid, read_entry, read_byte, free_cluster, found,
		input ready);
	modport sink (input valid, read_entry, read_byte, free_cluster, found,
		output ready);
endinterface

// ----- sv/fat12pt_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module fat12pt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 3072
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- sv/fat12pt_ctrl.sv -----
// Sequencer of the FAT12 table engine: clearing pass, entry read-modify-write,
// byte access and the pipelined free-cluster scan over the two byte banks.
// Depends on fat12pt_pkg and fat12pt_req_if.
module fat12pt_ctrl
	import fat12pt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	fat12pt_req_if.sink       req,
	output res_t              res,
	input  logic              res_ready,
	output mem_req_t          ev_req,
	output mem_req_t          od_req,
	input  logic [BYTE_W-1:0] ev_rdata,
	input  logic [BYTE_W-1:0] od_rdata
);
	state_t             state_q;
	logic [BA_W-1:0]    clr_q;
	func_t              func_q;
	logic [CL_W-1:0]    cluster_q;
	logic [EV_W-1:0]    value_q;
	logic [BADDR_W-1:0] addr_q;
	logic [SCAN_W-1:0]  scan_n_q;
	logic               chk_v_s1;
	logic [CL_W-1:0]    n_s1;
	logic [CL_W-1:0]    rd_entry_q;
	logic [BYTE_W-1:0]  rd_byte_q;
	logic [CL_W-1:0]    free_q;
	logic               found_q;

	logic               accept;
	logic [CL_W-1:0]    acc_n;
	logic [OFF_W-1:0]   acc_off;
	logic [OFF_W-1:0]   acc_off1;
	logic [OFF_W-1:0]   in_addr_x;
	logic               in_byte_ok;
	logic [CL_W-1:0]    cur_n;
	logic [OFF_W-1:0]   cur_off;
	logic               cur_in;
	logic [BYTE_W-1:0]  lo_b;
	logic [BYTE_W-1:0]  hi_b;
	logic [CL_W-1:0]    cur_entry;
	logic [BYTE_W-1:0]  lo_new;
	logic [BYTE_W-1:0]  hi_new;
	logic [BYTE_W-1:0]  byte_val;
	logic               byte_ok;
	logic               scan_more;
	logic               scan_hit;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	// Address side: the entry whose bytes are fetched this cycle.
	always_comb begin
		if (state_q == ST_SCAN) begin
			acc_n = CL_W'(scan_n_q);
		end else if (state_q == ST_IDLE) begin
			acc_n = req.cluster;
		end else begin
			acc_n = cluster_q;
		end
	end
	assign acc_off    = entry_off(acc_n);
	assign acc_off1   = acc_off + OFF_W'(1);
	assign in_addr_x  = OFF_W'(req.byte_addr);
	assign in_byte_ok = in_addr_x < OFF_W'(TABLE_BYTES);

	// Data side: the entry whose bytes arrive from the banks this cycle.
	assign cur_n   = (state_q == ST_SCAN) ? n_s1 : cluster_q;
	assign cur_off = entry_off(cur_n);
	assign cur_in  = entry_inside(cur_off);
	assign lo_b    = cur_off[0] ? od_rdata : ev_rdata;
	assign hi_b    = cur_off[0] ? ev_rdata : od_rdata;
	assign cur_entry = cur_n[0] ? {hi_b, lo_b[7:4]} : {hi_b[3:0], lo_b};

	// Write entry keeps the neighbouring entry's nibble.
	assign lo_new = cluster_q[0] ? {value_q[3:0], lo_b[3:0]} : value_q[7:0];
	assign hi_new = cluster_q[0] ? value_q[11:4] : {hi_b[7:4], value_q[11:8]};

	assign byte_val = addr_q[0] ? od_rdata : ev_rdata;
	assign byte_ok  = OFF_W'(addr_q) < OFF_W'(TABLE_BYTES);

	assign scan_more = scan_n_q < SCAN_W'(SCAN_END);
	assign scan_hit  = chk_v_s1 && cur_in && (cur_entry == '0);

	always_comb begin
		ev_req       = '0;
		od_req       = '0;
		ev_req.raddr = acc_off1[BA_W:1];
		od_req.raddr = acc_off[BA_W:1];
		unique case (state_q)
			ST_CLEAR: begin
				ev_req.we    = 1'b1;
				ev_req.waddr = clr_q;
				od_req.we    = 1'b1;
				od_req.waddr = clr_q;
			end
			ST_IDLE: begin
				if (func_t'(req.func) == FN_READ_BYTE || func_t'(req.func) == FN_LOAD_BYTE) begin
					ev_req.raddr = in_addr_x[BA_W:1];
					od_req.raddr = in_addr_x[BA_W:1];
				end
				ev_req.waddr = in_addr_x[BA_W:1];
				ev_req.wdata = req.byte_data;
				od_req.waddr = in_addr_x[BA_W:1];
				od_req.wdata = req.byte_data;
				if (accept && func_t'(req.func) == FN_LOAD_BYTE && in_byte_ok) begin
					ev_req.we = !req.byte_addr[0];
					od_req.we = req.byte_addr[0];
				end
			end
			ST_ACCESS: begin
				ev_req.waddr = acc_off1[BA_W:1];
				ev_req.wdata = cur_off[0] ? hi_new : lo_new;
				od_req.waddr = acc_off[BA_W:1];
				od_req.wdata = cur_off[0] ? lo_new : hi_new;
				if (func_q == FN_WRITE_ENTRY && cur_in) begin
					ev_req.we = 1'b1;
					od_req.we = 1'b1;
				end
			end
			ST_SCAN, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			scan_n_q <= '0;
			chk_v_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + BA_W'(1);
					if (clr_q == BA_W'(BANK_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (func_t'(req.func))
							FN_READ_ENTRY, FN_WRITE_ENTRY, FN_READ_BYTE: begin
								state_q <= ST_ACCESS;
							end
							FN_FIND_FREE: begin
								state_q  <= ST_SCAN;
								scan_n_q <= SCAN_W'(FIRST_DATA_CLUSTER);
								chk_v_s1 <= 1'b0;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_ACCESS: begin
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (scan_hit || (!chk_v_s1 && !scan_more)) begin
						state_q <= ST_DONE;
					end
					chk_v_s1 <= scan_more;
					if (scan_more) begin
						scan_n_q <= scan_n_q + SCAN_W'(1);
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q     <= func_t'(req.func);
			cluster_q  <= req.cluster;
			value_q    <= req.entry_value;
			addr_q     <= req.byte_addr;
			rd_entry_q <= '0;
			rd_byte_q  <= '0;
			free_q     <= '0;
			found_q    <= 1'b0;
		end
		if (state_q == ST_ACCESS) begin
			if (func_q == FN_READ_ENTRY) begin
				rd_entry_q <= cur_in ? cur_entry : '0;
			end
			if (func_q == FN_READ_BYTE) begin
				rd_byte_q <= byte_ok ? byte_val : '0;
			end
		end
		if (state_q == ST_SCAN) begin
			n_s1 <= CL_W'(scan_n_q);
			if (scan_hit) begin
				free_q  <= n_s1;
				found_q <= 1'b1;
			end
		end
	end

	assign res.valid        = (state_q == ST_DONE);
	assign res.read_entry   = rd_entry_q;
	assign res.read_byte    = rd_byte_q;
	assign res.free_cluster = free_q;
	assign res.found        = found_q;
endmodule

// ----- sv/fat12_packed_table_engine_unit.sv -----
// Top level of the FAT12 packed allocation table engine: sequencer, two byte banks
// and the output register. Depends on fat12pt_pkg, the channel interfaces,
// fat12pt_ram and fat12pt_ctrl.

// The table lives in two 3072 x 8 synchronous RAMs, one for even and one for odd
// byte addresses, so both bytes of a 12-bit entry come out in one read. After
// reset a clearing pass zeroes both banks, during which no request is taken.
// Requests are handled one at a time: read entry, write entry and read byte pass
// through the access state before their result is posted, while load byte and
// unused codes post their result straight from idle. Find free reads one entry
// per cycle, bound by the single read port of each bank.
// A finished result waits in the output register while the next request is taken.
module fat12_packed_table_engine_unit
	import fat12pt_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	fat12pt_req_if.sink   req,
	fat12pt_rsp_if.source rsp
);
	res_t              res;
	logic              res_ready;
	mem_req_t          ev_req;
	mem_req_t          od_req;
	logic [BYTE_W-1:0] ev_rdata;
	logic [BYTE_W-1:0] od_rdata;

	logic              out_valid_q;
	logic [CL_W-1:0]   out_entry_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [CL_W-1:0]   out_free_q;
	logic              out_found_q;

	fat12pt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.res_ready (res_ready),
		.ev_req    (ev_req),
		.od_req    (od_req),
		.ev_rdata  (ev_rdata),
		.od_rdata  (od_rdata)
	);

	fat12pt_ram #(.WIDTH(BYTE_W), .DEPTH(BANK_DEPTH)) u_ram_even (
		.clk   (clk),
		.we    (ev_req.we),
		.waddr (ev_req.waddr),
		.wdata (ev_req.wdata),
		.raddr (ev_req.raddr),
		.rdata (ev_rdata)
	);

	fat12pt_ram #(.WIDTH(BYTE_W), .DEPTH(BANK_DEPTH)) u_ram_odd (
		.clk   (clk),
		.we    (od_req.we),
		.waddr (od_req.waddr),
		.wdata (od_req.wdata),
		.raddr (od_req.raddr),
		.rdata (od_rdata)
	);

	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			out_entry_q <= res.read_entry;
			out_byte_q  <= res.read_byte;
			out_free_q  <= res.free_cluster;
			out_found_q <= res.found;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.read_entry   = out_entry_q;
	assign rsp.read_byte    = out_byte_q;
	assign rsp.free_cluster = out_free_q;
	assign rsp.found        = out_found_q;
endmodule

// ----- sv/fat12pt_chk.sv -----
// Port-level checker for the FAT12 table engine, bound to the top level.
// Depends on fat12pt_pkg and fat12_packed_table_engine_unit_defines.svh.
`include "fat12_packed_table_engine_unit_defines.svh"

module fat12pt_chk
	import fat12pt_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [CL_W-1:0]   rsp_read_entry,
	input logic [BYTE_W-1:0] rsp_read_byte,
	input logic [CL_W-1:0]   rsp_free_cluster,
	input logic              rsp_found
);
	// A stalled result must hold until its transfer.
	`FAT12PT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_entry) && $stable(rsp_read_byte) && $stable(rsp_free_cluster) && $stable(rsp_found))

	// Requests are processed one at a time.
	`FAT12PT_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_valid && req_ready, !req_ready)

	// A failed search reports cluster zero.
	`FAT12PT_ASSERT(a_not_found_zero, clk, arst_n, rsp_valid && !rsp_found, rsp_free_cluster == '0)

	// A found cluster lies in the data area and the other fields are zero.
	`FAT12PT_ASSERT(a_found_range, clk, arst_n, rsp_valid && rsp_found, rsp_free_cluster >= FIRST_DATA_CLUSTER && rsp_free_cluster < SCAN_END && rsp_read_entry == '0 && rsp_read_byte == '0)
endmodule

bind fat12_packed_table_engine_unit fat12pt_chk u_fat12pt_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_read_entry   (rsp.read_entry),
	.rsp_read_byte    (rsp.read_byte),
	.rsp_free_cluster (rsp.free_cluster),
	.rsp_found        (rsp.found)
);

// ----- tb/tb_fat12_packed_table_engine_unit.sv -----
// Self-checking testbench for the FAT12 packed allocation table engine.
// It keeps a shadow copy of the packed table and predicts one result per request transfer.
// Depends on fat12pt_pkg, fat12pt_req_if, fat12pt_rsp_if and fat12_packed_table_engine_unit.
module tb_fat12_packed_table_engine_unit
	import fat12pt_pkg::*;
;

	localparam int IDLE_PCT        = 22;
	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int PRESSURE_CYCLES = 300;
	localparam int PRESSURE_AT     = 90;
	localparam int DRAIN_CYCLES    = 20;
	localparam int RANDOM_ITEMS    = 100;
	localparam int STEADY_FIRST    = 60;
	localparam int STEADY_LAST     = 130;

	localparam logic [FUNC_W-1:0] FN_UNUSED_FIRST = 3'd5;
	localparam logic [FUNC_W-1:0] FN_UNUSED_LAST  = 3'd7;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [CL_W-1:0]    cluster;
		logic [EV_W-1:0]    entry_value;
		logic [BADDR_W-1:0] byte_addr;
		logic [BYTE_W-1:0]  byte_data;
	} fat_op_t;

	typedef struct packed {
		logic [CL_W-1:0]   read_entry;
		logic [BYTE_W-1:0] read_byte;
		logic [CL_W-1:0]   free_cluster;
		logic              found;
	} fat_result_t;

	logic clk;
	logic arst_n;

	fat12pt_req_if req_ch ();
	fat12pt_rsp_if rsp_ch ();

	fat12_packed_table_engine_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [7:0]  fat_shadow [0:TABLE_BYTES-1];
	fat_op_t     pending_ops [$];
	fat_result_t expected_results [$];
	fat_op_t     op_on_bus;
	fat_result_t result_seen;
	fat_result_t result_due;
	fat_result_t result_calc;
	int          ops_sent;
	int          results_seen;
	int          errors;
	int          stall_left;
	bit          stall_done;
	int          quiet_cycles;

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.func        = '0;
		req_ch.cluster     = '0;
		req_ch.entry_value = '0;
		req_ch.byte_addr   = '0;
		req_ch.byte_data   = '0;
		rsp_ch.ready       = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		forever #5 clk = ~clk;
	end

	// Entry n is packed little-endian at byte n + n/2; odd entries use the upper 12 bits.
	function automatic logic [CL_W-1:0] shadow_entry(input int n);
		int          off;
		logic [15:0] word;
		off = n + n / 2;
		if (off + 1 >= TABLE_BYTES) return '0;
		word = {fat_shadow[off + 1], fat_shadow[off]};
		return n[0] ? word[15:4] : word[11:0];
	endfunction

	task automatic predict_result(input fat_op_t op, output fat_result_t res);
		int n;
		int off;
		bit hit;
		res = '0;
		n   = int'(op.cluster);
		off = n + n / 2;
		hit = 1'b0;
		case (op.func)
			FN_READ_ENTRY: begin
				res.read_entry = shadow_entry(n);
			end
			FN_WRITE_ENTRY: begin
				if (off + 1 < TABLE_BYTES) begin
					if (n[0]) begin
						fat_shadow[off][7:4] = op.entry_value[3:0];
						fat_shadow[off + 1]  = op.entry_value[11:4];
					end else begin
						fat_shadow[off]          = op.entry_value[7:0];
						fat_shadow[off + 1][3:0] = op.entry_value[11:8];
					end
				end
			end
			FN_FIND_FREE: begin
				for (int c = 2; c < SCAN_END; c++) begin
					if (!hit && (c + c / 2 + 1 < TABLE_BYTES) && shadow_entry(c) == '0) begin
						hit              = 1'b1;
						res.free_cluster = CL_W'(c);
						res.found        = 1'b1;
					end
				end
			end
			FN_LOAD_BYTE: begin
				if (int'(op.byte_addr) < TABLE_BYTES) fat_shadow[op.byte_addr] = op.byte_data;
			end
			FN_READ_BYTE: begin
				if (int'(op.byte_addr) < TABLE_BYTES) res.read_byte = fat_shadow[op.byte_addr];
			end
			default: begin
			end
		endcase
	endtask

	task automatic queue_op(input logic [FUNC_W-1:0] f, input int cl, input int ev,
		input int ba, input int bd);
		fat_op_t op;
		op.func        = f;
		op.cluster     = CL_W'(cl);
		op.entry_value = EV_W'(ev);
		op.byte_addr   = BADDR_W'(ba);
		op.byte_data   = BYTE_W'(bd);
		pending_ops.push_back(op);
	endtask

	task automatic check_field(input string name, input int due, input int seen);
		if (due != seen) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, due, seen);
			errors++;
		end
	endtask

	// Small clusters keep writes close to where the free search starts.
	function automatic int pick_cluster();
		return ($urandom_range(3, 0) != 0) ? $urandom_range(63, 0) : $urandom_range(4095, 0);
	endfunction

	// Request driver: a new item goes out only once the previous one has transferred.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				predict_result(op_on_bus, result_calc);
				expected_results.push_back(result_calc);
				ops_sent++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_ops.size() != 0 &&
					((ops_sent >= STEADY_FIRST && ops_sent < STEADY_LAST) ||
					$urandom_range(99, 0) >= IDLE_PCT)) begin
					op_on_bus = pending_ops.pop_front();
					req_ch.valid       <= 1'b1;
					req_ch.func        <= op_on_bus.func;
					req_ch.cluster     <= op_on_bus.cluster;
					req_ch.entry_value <= op_on_bus.entry_value;
					req_ch.byte_addr   <= op_on_bus.byte_addr;
					req_ch.byte_data   <= op_on_bus.byte_data;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor. Once, it holds ready low long enough for the engine to back up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				result_seen.read_entry   = rsp_ch.read_entry;
				result_seen.read_byte    = rsp_ch.read_byte;
				result_seen.free_cluster = rsp_ch.free_cluster;
				result_seen.found        = rsp_ch.found;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %0h", $time,
						result_seen);
					errors++;
				end else begin
					result_due = expected_results.pop_front();
					check_field("read_entry", result_due.read_entry, result_seen.read_entry);
					check_field("read_byte", result_due.read_byte, result_seen.read_byte);
					check_field("free_cluster", result_due.free_cluster,
						result_seen.free_cluster);
					check_field("found", result_due.found, result_seen.found);
				end
				results_seen++;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!stall_done && results_seen >= PRESSURE_AT) begin
				stall_done = 1'b1;
				stall_left = PRESSURE_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= (results_seen >= STEADY_FIRST && results_seen < STEADY_LAST) ||
					($urandom_range(99, 0) >= IDLE_PCT);
			end
		end
	end

	// Watchdog on cycles without any transfer; covers the clearing pass and a full scan.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("fat12_packed_table_engine_unit regression: fail");
				$finish;
			end
		end
	end

	initial begin
		int kind;
		int cl;
		int ba;
		int ev;
		int added;
		int total_ops;
		ops_sent     = 0;
		results_seen = 0;
		errors       = 0;
		stall_left   = 0;
		stall_done   = 1'b0;
		quiet_cycles = 0;
		for (int i = 0; i < TABLE_BYTES; i++) fat_shadow[i] = '0;

		// Directed part: cleared store, packing of neighbors, store edges, unused codes.
		queue_op(FN_READ_ENTRY, 0, 0, 0, 0);
		queue_op(FN_FIND_FREE, 0, 0, 0, 0);
		queue_op(FN_WRITE_ENTRY, 2, 12'hFFF, 0, 0);
		queue_op(FN_WRITE_ENTRY, 3, 12'hABC, 0, 0);
		queue_op(FN_READ_ENTRY, 2, 0, 0, 0);
		queue_op(FN_READ_BYTE, 0, 0, 3, 0);
		queue_op(FN_READ_BYTE, 0, 0, 4, 0);
		queue_op(FN_READ_BYTE, 0, 0, 5, 0);
		queue_op(FN_WRITE_ENTRY, 2, 0, 0, 0);
		queue_op(FN_READ_ENTRY, 3, 0, 0, 0);
		queue_op(FN_FIND_FREE, 0, 0, 0, 0);
		queue_op(FN_WRITE_ENTRY, 2, 1, 0, 0);
		queue_op(FN_FIND_FREE, 0, 0, 0, 0);
		queue_op(FN_WRITE_ENTRY, 4095, 12'hFFF, 8191, 255);
		queue_op(FN_READ_ENTRY, 4094, 0, 0, 0);
		queue_op(FN_READ_BYTE, 0, 0, TABLE_BYTES - 1, 0);
		queue_op(FN_LOAD_BYTE, 0, 0, TABLE_BYTES - 1, 8'h5A);
		queue_op(FN_READ_ENTRY, 4095, 0, 0, 0);
		queue_op(FN_LOAD_BYTE, 0, 0, 8191, 8'hFF);
		queue_op(FN_READ_BYTE, 0, 0, 8191, 0);
		queue_op(FN_READ_BYTE, 0, 0, TABLE_BYTES, 0);
		for (int f = FN_UNUSED_FIRST; f <= FN_UNUSED_LAST; f++)
			queue_op(FUNC_W'(f), 4095, 4095, 8191, 255);
		queue_op(FN_WRITE_ENTRY, 1, 12'h456, 0, 0);
		queue_op(FN_READ_ENTRY, 1, 0, 0, 0);

		// Random part: mostly write/read and load/read pairs plus free searches.
		added = 0;
		while (added < RANDOM_ITEMS) begin
			kind = $urandom_range(99, 0);
			cl   = pick_cluster();
			ba   = ($urandom_range(3, 0) != 0) ? $urandom_range(95, 0) : $urandom_range(8191, 0);
			ev   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(4095, 0);
			if (kind < 30) begin
				queue_op(FN_WRITE_ENTRY, cl, ev, $urandom_range(8191, 0), $urandom_range(255, 0));
				queue_op(FN_READ_ENTRY, cl, $urandom_range(4095, 0), $urandom_range(8191, 0),
					$urandom_range(255, 0));
				added += 2;
			end else if (kind < 50) begin
				queue_op(FN_LOAD_BYTE, $urandom_range(4095, 0), $urandom_range(4095, 0), ba,
					$urandom_range(255, 0));
				queue_op(FN_READ_BYTE, $urandom_range(4095, 0), $urandom_range(4095, 0), ba,
					$urandom_range(255, 0));
				added += 2;
			end else if (kind < 65) begin
				queue_op(FN_FIND_FREE, $urandom_range(4095, 0), $urandom_range(4095, 0),
					$urandom_range(8191, 0), $urandom_range(255, 0));
				added++;
			end else if (kind < 80) begin
				queue_op(FN_READ_ENTRY, $urandom_range(4095, 0), $urandom_range(4095, 0),
					$urandom_range(8191, 0), $urandom_range(255, 0));
				added++;
			end else if (kind < 90) begin
				queue_op(FN_READ_BYTE, $urandom_range(4095, 0), $urandom_range(4095, 0),
					$urandom_range(8191, 0), $urandom_range(255, 0));
				added++;
			end else if (kind < 95) begin
				queue_op(FN_WRITE_ENTRY, $urandom_range(4095, 0), $urandom_range(4095, 0),
					$urandom_range(8191, 0), $urandom_range(255, 0));
				added++;
			end else begin
				queue_op(FUNC_W'($urandom_range(FN_UNUSED_LAST, FN_UNUSED_FIRST)),
					$urandom_range(4095, 0), $urandom_range(4095, 0), $urandom_range(8191, 0),
					$urandom_range(255, 0));
				added++;
			end
		end

		// Occupy the first data clusters, then reopen single holes among them.
		for (int c = 2; c < 8; c++)
			queue_op(FN_WRITE_ENTRY, c, $urandom_range(4095, 1), 0, 0);
		queue_op(FN_FIND_FREE, 0, 0, 0, 0);
		queue_op(FN_WRITE_ENTRY, 5, 0, 0, 0);
		queue_op(FN_FIND_FREE, 0, 0, 0, 0);
		queue_op(FN_WRITE_ENTRY, 2, 0, 0, 0);
		queue_op(FN_FIND_FREE, 0, 0, 0, 0);

		total_ops = pending_ops.size();
		while (results_seen < total_ops)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("fat12_packed_table_engine_unit regression: pass");
		else
			$display("fat12_packed_table_engine_unit regression: fail");
		$finish;
	end

endmodule
